// ----- rtl/sps_pkg.sv -----
// Package with widths, register indexes and reset values for the sphere plane slicer.
package sps_pkg;
  localparam int NormW = 18;
  localparam int CoordW = 32;
  localparam int RadW = 31;
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegNx = 2'd0;
  localparam logic [CfgIdxW-1:0] RegNy = 2'd1;
  localparam logic [CfgIdxW-1:0] RegNz = 2'd2;
  localparam logic [CfgIdxW-1:0] RegOff = 2'd3;
  localparam logic signed [NormW-1:0] NzReset = 18'sd65536;
  localparam int SqW = 62;
  localparam int RootW = 31;
  localparam int RootPerStage = 4;
  localparam int RootStages = (RootW + RootPerStage - 1) / RootPerStage;
endpackage

// ----- rtl/sps_root.sv -----
// Pipelined restoring integer square root, RootPerStage (4) result bits per stage.
module sps_root
  import sps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [SqW-1:0]    in_sq,
  input  logic [3*CoordW-1:0] in_tag,
  output logic              out_vld,
  output logic [RootW-1:0]  out_root,
  output logic [3*CoordW-1:0] out_tag
);
  localparam int NBits = RootStages * RootPerStage;
  localparam int RemW = RootW + 2;

  logic [RootStages-1:0]     vld_r;
  logic [2*NBits-1:0]        rad_r   [RootStages];
  logic [RemW-1:0]           rem_r   [RootStages];
  logic [RootW-1:0]          q_r     [RootStages];
  logic [3*CoordW-1:0]       tag_r   [RootStages];
  logic [2*NBits-1:0]        rad_nxt [RootStages];
  logic [RemW-1:0]           rem_nxt [RootStages];
  logic [RootW-1:0]          q_nxt   [RootStages];

  always_comb begin
    logic [RemW+1:0]    trial;
    logic [RemW+1:0]    acc;
    logic [2*NBits-1:0] rad;
    logic [RemW-1:0]    rem;
    logic [RootW-1:0]   q;
    rad = {{(2*NBits-SqW){1'b0}}, in_sq};
    rem = '0;
    q = '0;
    for (int s = 0; s < RootStages; s++) begin
      for (int b = 0; b < RootPerStage; b++) begin
        acc = {rem, rad[2*NBits-1 -: 2]};
        trial = {2'b00, q, 2'b01};
        rad = rad << 2;
        if (acc >= trial) begin
          rem = RemW'(acc - trial);
          q = {q[RootW-2:0], 1'b1};
        end else begin
          rem = RemW'(acc);
          q = {q[RootW-2:0], 1'b0};
        end
      end
      rad_nxt[s] = rad;
      rem_nxt[s] = rem;
      q_nxt[s] = q;
      rad = rad_r[s];
      rem = rem_r[s];
      q = q_r[s];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[RootStages-2:0], in_vld};
    end
    for (int s = 0; s < RootStages; s++) begin
      rad_r[s] <= rad_nxt[s];
      rem_r[s] <= rem_nxt[s];
      q_r[s] <= q_nxt[s];
    end
    tag_r[0] <= in_tag;
    for (int s = 1; s < RootStages; s++) begin
      tag_r[s] <= tag_r[s-1];
    end
  end

  assign out_vld = vld_r[RootStages-1];
  assign out_root = q_r[RootStages-1];
  assign out_tag = tag_r[RootStages-1];
endmodule

// ----- rtl/sphere_plane_slice.sv -----
// Top level of the sphere plane slicer: distance, hit test, circle center and radius.
// From start to out_valid: stages 1 to 5, the sps_root pipeline, the output register.
// Throughput: one item per cycle; busy stays low.
// The receiver cannot stall; each result shows for one cycle with out_valid.
// Reset (synchronous, rst_n low) clears the pipeline valid bits and sets the plane
// to normal (0, 0, 1) and offset 0.
module sphere_plane_slice
  import sps_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [CoordW-1:0] in_sphere_x,
  input  logic signed [CoordW-1:0] in_sphere_y,
  input  logic signed [CoordW-1:0] in_sphere_z,
  input  logic [RadW-1:0]          in_sphere_radius,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CfgIdxW-1:0]       cfg_index,
  input  logic [CoordW-1:0]        cfg_data,
  output logic                     out_valid,
  output logic signed [CoordW-1:0] out_circle_x,
  output logic signed [CoordW-1:0] out_circle_y,
  output logic signed [CoordW-1:0] out_circle_z,
  output logic [RadW-1:0]          out_circle_radius
);
  logic signed [NormW-1:0]  nx_r, ny_r, nz_r;
  logic signed [CoordW-1:0] off_r;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r <= '0;
      ny_r <= '0;
      nz_r <= NzReset;
      off_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegNx:   nx_r <= cfg_data[NormW-1:0];
        RegNy:   ny_r <= cfg_data[NormW-1:0];
        RegNz:   nz_r <= cfg_data[NormW-1:0];
        RegOff:  off_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: three products.
  logic                     v1_r;
  logic signed [49:0]       px_r, py_r, pz_r;
  logic signed [CoordW-1:0] c1x_r, c1y_r, c1z_r;
  logic [RadW-1:0]          r1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= start;
    px_r <= nx_r * in_sphere_x;
    py_r <= ny_r * in_sphere_y;
    pz_r <= nz_r * in_sphere_z;
    c1x_r <= in_sphere_x;
    c1y_r <= in_sphere_y;
    c1z_r <= in_sphere_z;
    r1_r <= in_sphere_radius;
  end

  // Stage 2: distance sum.
  logic                     v2_r;
  logic signed [51:0]       dx_r;
  logic signed [CoordW-1:0] c2x_r, c2y_r, c2z_r;
  logic [RadW-1:0]          r2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
    dx_r <= 52'(px_r) + 52'(py_r) + 52'(pz_r) + {{4{off_r[CoordW-1]}}, off_r, 16'd0};
    c2x_r <= c1x_r;
    c2y_r <= c1y_r;
    c2z_r <= c1z_r;
    r2_r <= r1_r;
  end

  // Stage 3: hit test and distance with its 16 fraction bits dropped (floor).
  logic                     v3_r, hit3_r;
  logic signed [35:0]       d3_r;
  logic signed [CoordW-1:0] c3x_r, c3y_r, c3z_r;
  logic [RadW-1:0]          r3_r;
  logic [51:0]              mag;
  assign mag = dx_r[51] ? 52'(-dx_r) : 52'(dx_r);
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else v3_r <= v2_r;
    hit3_r <= mag < {5'd0, r2_r, 16'd0};
    d3_r <= dx_r[51:16];
    c3x_r <= c2x_r;
    c3y_r <= c2y_r;
    c3z_r <= c2z_r;
    r3_r <= r2_r;
  end

  // Stage 4: products for the center and the radius square.
  logic                     v4_r;
  logic signed [53:0]       qx_r, qy_r, qz_r;
  logic [61:0]              rr_r, dd_r;
  logic signed [CoordW-1:0] c4x_r, c4y_r, c4z_r;
  logic [31:0]              dabs;
  assign dabs = d3_r[35] ? 32'(-d3_r) : 32'(d3_r);
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else v4_r <= v3_r && hit3_r;
    qx_r <= d3_r * nx_r;
    qy_r <= d3_r * ny_r;
    qz_r <= d3_r * nz_r;
    rr_r <= r3_r * r3_r;
    dd_r <= 62'(dabs * dabs);
    c4x_r <= c3x_r;
    c4y_r <= c3y_r;
    c4z_r <= c3z_r;
  end

  // Stage 5: center and saturation, radius difference.
  function automatic logic signed [CoordW-1:0] sat_ctr(
    input logic signed [CoordW-1:0] c, input logic signed [53:0] q);
    logic signed [54:0] t;
    logic signed [38:0] f;
    begin
      t = {{7{c[CoordW-1]}}, c, 16'd0} - 55'(q);
      f = t[54:16];
      if (f > 39'sd2147483647) sat_ctr = 32'sh7fffffff;
      else if (f < -39'sd2147483648) sat_ctr = 32'sh80000000;
      else sat_ctr = f[CoordW-1:0];
    end
  endfunction

  logic                     v5_r;
  logic [SqW-1:0]           sq5_r;
  logic [3*CoordW-1:0]      ctr5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else v5_r <= v4_r;
    sq5_r <= rr_r - dd_r;
    ctr5_r <= {sat_ctr(c4x_r, qx_r), sat_ctr(c4y_r, qy_r), sat_ctr(c4z_r, qz_r)};
  end

  logic                rv;
  logic [RootW-1:0]    root;
  logic [3*CoordW-1:0] tag;
  sps_root u_root (
    .clk(clk), .rst_n(rst_n), .in_vld(v5_r), .in_sq(sq5_r), .in_tag(ctr5_r),
    .out_vld(rv), .out_root(root), .out_tag(tag)
  );

  logic v6_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else v6_r <= rv;
    out_circle_radius <= root;
    {out_circle_x, out_circle_y, out_circle_z} <= tag;
  end
  assign out_valid = v6_r;

`ifndef SYNTHESIS
  a_no_miss_hit: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !hit3_r |=> !v4_r) else $error("missed item passed hit test");
  a_hit_chain: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |=> v5_r) else $error("hit item lost");
  a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> rr_r >= dd_r) else $error("distance exceeds radius");
  a_no_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
`endif
endmodule

// ----- tb/sphere_plane_slice_test.sv -----
// Self-checking testbench for the sphere plane slicer with random and directed spheres.
`timescale 1ns / 1ps

module sphere_plane_slice_test;
  import sps_pkg::*;

  localparam int Latency = 6 + RootStages;
  localparam int WatchdogLimit = 20000;

  typedef struct packed {
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] cz;
    logic [RadW-1:0]          cr;
  } circle_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [CoordW-1:0] in_sphere_x;
  logic signed [CoordW-1:0] in_sphere_y;
  logic signed [CoordW-1:0] in_sphere_z;
  logic [RadW-1:0] in_sphere_radius;
  logic cfg_valid;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CoordW-1:0] cfg_data;
  logic out_valid;
  logic signed [CoordW-1:0] out_circle_x;
  logic signed [CoordW-1:0] out_circle_y;
  logic signed [CoordW-1:0] out_circle_z;
  logic [RadW-1:0] out_circle_radius;

  logic signed [NormW-1:0] plane_nx;
  logic signed [NormW-1:0] plane_ny;
  logic signed [NormW-1:0] plane_nz;
  logic signed [CoordW-1:0] plane_off;

  circle_t expected_circles[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int idle_pct;

  sphere_plane_slice u_dut (.*);

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic signed [CoordW-1:0] sat_coord(logic signed [95:0] v);
    if (v > 96'sh7fffffff) return 32'sh7fffffff;
    if (v < -96'sh80000000) return 32'sh80000000;
    return v[CoordW-1:0];
  endfunction

  function automatic logic [63:0] int_root(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Returns 1 and the circle when the sphere crosses the plane.
  function automatic bit slice_sphere(circle_t s, output circle_t c);
    logic signed [95:0] dsum;
    logic signed [95:0] mag;
    logic signed [95:0] d;
    logic signed [95:0] rr;
    rr = $signed({65'd0, s.cr});
    dsum = ($signed(plane_off) <<< 16) + plane_nx * s.cx + plane_ny * s.cy
           + plane_nz * s.cz;
    mag = dsum < 0 ? -dsum : dsum;
    if (!(mag < (rr <<< 16))) return 0;
    d = dsum >>> 16;
    c.cx = sat_coord(((($signed(s.cx)) <<< 16) - d * plane_nx) >>> 16);
    c.cy = sat_coord(((($signed(s.cy)) <<< 16) - d * plane_ny) >>> 16);
    c.cz = sat_coord(((($signed(s.cz)) <<< 16) - d * plane_nz) >>> 16);
    c.cr = RadW'(int_root(64'(rr * rr - d * d)));
    return 1;
  endfunction

  always @(posedge clk) begin
    circle_t got;
    circle_t want;
    if (rst_n && out_valid) begin
      got = '{out_circle_x, out_circle_y, out_circle_z, out_circle_radius};
      if (expected_circles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected circle %h", got);
      end else begin
        want = expected_circles.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Circle mismatch: expected %h %h %h %h, got %h %h %h %h",
                     want.cx, want.cy, want.cz, want.cr, got.cx, got.cy, got.cz, got.cr);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_sphere(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [30:0] r);
    circle_t s;
    circle_t c;
    while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_sphere_x <= x;
    in_sphere_y <= y;
    in_sphere_z <= z;
    in_sphere_radius <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    s = '{x, y, z, r};
    if (slice_sphere(s, c)) expected_circles = {expected_circles, c};
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_circles.size() != 0) @(posedge clk);
    repeat (Latency + 2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      RegNx: plane_nx = val[NormW-1:0];
      RegNy: plane_ny = val[NormW-1:0];
      RegNz: plane_nz = val[NormW-1:0];
      default: plane_off = val;
    endcase
  endtask

  task automatic set_plane(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                           logic [31:0] off);
    drain();
    write_reg(RegNx, nx);
    write_reg(RegNy, ny);
    write_reg(RegNz, nz);
    write_reg(RegOff, off);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    idle_pct = 0;
    send_sphere(32'h0001_0000, 0, 32'h0000_8000, 31'h0001_0000);
    send_sphere(0, 0, 0, 31'd0);
    send_sphere(0, 0, 32'hffff_ffff, 31'h0000_0001);
    send_sphere(32'h7fff_ffff, 32'h8000_0000, 0, 31'h7fff_ffff);
    send_sphere(0, 0, 32'h8000_0000, 31'h7fff_ffff);
    send_sphere(0, 0, 32'h7fff_ffff, 31'h7fff_ffff);
    send_sphere(0, 0, 32'h0002_0000, 31'h0002_0000);
    set_plane(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h7fff_ffff);
    send_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff);
    send_sphere(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
    set_plane(32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 32'h8000_0000);
    send_sphere(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
    send_sphere(32'h8000_0000, 0, 32'h4000_0000, 31'h7fff_ffff);
    set_plane(0, 0, 0, 32'h0000_1000);
    send_sphere(32'h1234_5678, 32'h9abc_def0, 32'h0, 31'h0000_2000);
    send_sphere(32'h1234_5678, 32'h9abc_def0, 32'h0, 31'h0000_0800);
    set_plane(32'hfffe_0000, 32'hffff_ffff, 32'h0000_ffff, 32'hffff_ffff);
    send_sphere(32'h0000_0001, 32'hffff_0000, 32'h0003_0000, 31'h0004_0000);
  endtask

  task automatic test_random(int count);
    logic [31:0] n[3];
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) begin
        foreach (n[k]) n[k] = $urandom_range(3, 0) == 0 ? $urandom
                                : 32'($signed($urandom_range(131072, 0)) - 65536);
        set_plane(n[0], n[1], n[2], $urandom_range(1, 0) ? $urandom
                  : 32'($signed($urandom_range(2000000, 0)) - 1000000));
      end
      idle_pct = (i >= 300 && i < 450) ? 0 : 22;
      case ($urandom_range(3, 0))
        0: send_sphere($urandom, $urandom, $urandom, 31'($urandom));
        default: send_sphere(32'($signed($urandom_range(4000000, 0)) - 2000000),
                             32'($signed($urandom_range(4000000, 0)) - 2000000),
                             32'($signed($urandom_range(4000000, 0)) - 2000000),
                             31'($urandom_range(3000000, 0)));
      endcase
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_sphere_x = '0;
    in_sphere_y = '0;
    in_sphere_z = '0;
    in_sphere_radius = '0;
    plane_nx = '0;
    plane_ny = '0;
    plane_nz = NzReset;
    plane_off = '0;
    idle_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(750);
    drain();
    if (mismatches == 0 && expected_circles.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/sps_pkg.sv
rtl/sps_root.sv
rtl/sphere_plane_slice.sv
tb/sphere_plane_slice_test.sv
